// File: src/assert_macros.svh
// Assertion macros shared by the checker files of the block.
// Needs nothing else; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on a given clock with an active-low reset that disables it.
`define ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Assertion on the block's usual clock and reset names.
`define ASSERT_DEF(label, prop) \
  `ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

// File: src/bfla_pkg.sv
// Shared types and constants of the block free list allocator.
// Used by the controller, the datapath, the top level and the checker.
package bfla_pkg;

  // Field widths fixed by the interface.
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;

  // Largest pool that the index field can address.
  localparam int INDEX_SPAN = 4096;

  // Default capacity of the link memory.
  localparam int MAX_BLOCKS_DEF = 4096;

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } bfla_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and start the link read
    logic commit;   // apply the update and load the result register
  } bfla_cmd_t;

endpackage

// File: src/bfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the link memory of the free list.
module bfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/bfla_ctrl.sv
// Controller of the allocator: request sequencing and output handshake.
// Depends on bfla_pkg for the state enum and the command struct.
module bfla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfla_pkg::bfla_cmd_t cmd_o
);

  bfla_pkg::bfla_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfla_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfla_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bfla_pkg::ST_EXEC;
        end
      end
      bfla_pkg::ST_EXEC: begin
        if (cmd_o.commit) begin
          state_d = bfla_pkg::ST_IDLE;
        end
      end
      default: state_d = bfla_pkg::ST_IDLE;
    endcase
  end

  // Outputs. A request commits once the result register is empty or drains.
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      bfla_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      bfla_pkg::ST_EXEC: begin
        cmd_o.commit = !out_valid_q || !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // The result word stays until taken unless a new one replaces it.
  assign out_valid_d = cmd_o.commit | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/bfla_dp.sv
// Datapath of the allocator: pool state, link memory and result register.
// Depends on bfla_pkg and instantiates bfla_ram for the link memory.
module bfla_dp #(
  parameter int MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfla_pkg::bfla_cmd_t        cmd_i,
  input  logic                       op_i,
  input  logic [bfla_pkg::IDX_W-1:0] freed_index_i,
  input  logic                       cfg_we_i,
  input  logic [bfla_pkg::CNT_W-1:0] cfg_wdata_i,
  output logic                       granted_o,
  output logic [bfla_pkg::IDX_W-1:0] granted_index_o,
  output logic [bfla_pkg::CNT_W-1:0] free_count_o,
  output logic                       pool_empty_o,
  output logic                       pool_full_o
);

  localparam int Depth = (MAX_BLOCKS > bfla_pkg::INDEX_SPAN) ?
                         bfla_pkg::INDEX_SPAN : MAX_BLOCKS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [bfla_pkg::CNT_W-1:0] Cap = bfla_pkg::CNT_W'(Depth);

  // Pool state.
  logic [bfla_pkg::CNT_W-1:0] blocks_q, blocks_d;
  logic [bfla_pkg::CNT_W-1:0] bump_q, bump_d;
  logic [bfla_pkg::IDX_W-1:0] head_q, head_d;
  logic                       nonempty_q, nonempty_d;
  logic [bfla_pkg::CNT_W-1:0] unused_q, unused_d;

  // Latched request.
  logic                       op_q;
  logic [bfla_pkg::IDX_W-1:0] idx_q;

  // Result register.
  logic                       granted_q;
  logic [bfla_pkg::IDX_W-1:0] gidx_q;
  logic [bfla_pkg::CNT_W-1:0] count_q;
  logic                       empty_q;
  logic                       full_q;

  logic [bfla_pkg::IDX_W-1:0] link_rdata;
  logic                       link_we;
  logic [bfla_pkg::CNT_W-1:0] cfg_blocks;
  logic                       alloc_bump;
  logic                       alloc_list;
  logic                       free_ok;
  logic                       res_granted;
  logic [bfla_pkg::IDX_W-1:0] res_gidx;

  // A written block count is held to the pool capacity.
  assign cfg_blocks = (cfg_wdata_i > Cap) ? Cap : cfg_wdata_i;

  // Request decode.
  assign alloc_bump = (op_q == bfla_pkg::OP_ALLOC) && (bump_q < blocks_q);
  assign alloc_list = (op_q == bfla_pkg::OP_ALLOC) && !(bump_q < blocks_q) &&
                      nonempty_q && (unused_q != '0);
  assign free_ok    = (op_q == bfla_pkg::OP_FREE) &&
                      ({1'b0, idx_q} < blocks_q) && (unused_q < blocks_q);

  // Next pool state for the request in flight.
  always_comb begin
    bump_d      = bump_q;
    head_d      = head_q;
    nonempty_d  = nonempty_q;
    unused_d    = unused_q;
    res_granted = 1'b0;
    res_gidx    = '0;
    if (alloc_bump) begin
      res_granted = 1'b1;
      res_gidx    = bump_q[bfla_pkg::IDX_W-1:0];
      bump_d      = bump_q + 1'b1;
      if (unused_q != '0) begin
        unused_d = unused_q - 1'b1;
      end
    end else if (alloc_list) begin
      res_granted = 1'b1;
      res_gidx    = head_q;
      head_d      = link_rdata;
      unused_d    = unused_q - 1'b1;
      nonempty_d  = (unused_q != bfla_pkg::CNT_W'(1));
    end else if (free_ok) begin
      head_d     = idx_q;
      nonempty_d = 1'b1;
      unused_d   = unused_q + 1'b1;
    end
  end

  // A register write sets up an empty pool of the new size.
  assign blocks_d = cfg_we_i ? cfg_blocks : blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q   <= Cap;
      bump_q     <= '0;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      unused_q   <= Cap;
    end else if (cfg_we_i) begin
      blocks_q   <= blocks_d;
      bump_q     <= '0;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      unused_q   <= cfg_blocks;
    end else if (cmd_i.commit) begin
      bump_q     <= bump_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      unused_q   <= unused_d;
    end
  end

  // Request and result words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      idx_q <= freed_index_i;
    end
    if (cmd_i.commit) begin
      granted_q <= res_granted;
      gidx_q    <= res_gidx;
      count_q   <= unused_d;
      empty_q   <= (unused_d == blocks_q);
      full_q    <= (unused_d == '0);
    end
  end

  // Link memory: the head's link is read as the request is taken, a free
  // writes the old head as the new head's link.
  assign link_we = cmd_i.commit && free_ok;

  bfla_ram #(
    .Width (bfla_pkg::IDX_W),
    .Depth (Depth)
  ) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (link_we),
    .wr_addr_i (idx_q[AddrW-1:0]),
    .wr_data_i (head_q),
    .rd_en_i   (cmd_i.capture),
    .rd_addr_i (head_q[AddrW-1:0]),
    .rd_data_o (link_rdata)
  );

  assign granted_o       = granted_q;
  assign granted_index_o = gidx_q;
  assign free_count_o    = count_q;
  assign pool_empty_o    = empty_q;
  assign pool_full_o     = full_q;

endmodule

// File: src/block_free_list_allocator_unit.sv
// Block free list allocator: top level joining controller and datapath.
// A request is taken in IDLE and commits in EXEC into the result register;
// an earlier result word still stalled at the output holds it in EXEC.
// No new request is taken until the last one commits, as a free list pop
// needs the registered link memory read before the head can move.
// Reset (asynchronous, active low): full pool of min(MAX_BLOCKS, 4096) blocks,
// empty free list, no result pending; the link memory is not cleared.
module block_free_list_allocator_unit #(
  parameter int MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [bfla_pkg::IDX_W-1:0] freed_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       granted_o,
  output logic [bfla_pkg::IDX_W-1:0] granted_index_o,
  output logic [bfla_pkg::CNT_W-1:0] free_count_o,
  output logic                       pool_empty_o,
  output logic                       pool_full_o,
  input  logic                       cfg_we_i,
  input  logic [bfla_pkg::CNT_W-1:0] cfg_wdata_i
);

  bfla_pkg::bfla_cmd_t cmd;

  // Request sequencing.
  bfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Pool state and link memory.
  bfla_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .freed_index_i   (freed_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .granted_o       (granted_o),
    .granted_index_o (granted_index_o),
    .free_count_o    (free_count_o),
    .pool_empty_o    (pool_empty_o),
    .pool_full_o     (pool_full_o)
  );

endmodule

// File: src/bfla_checker.sv
// Port-level checks of the block free list allocator, bound to the top level.
// Depends on assert_macros.svh and bfla_pkg.
`include "assert_macros.svh"

module bfla_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       granted_o,
  input logic [bfla_pkg::IDX_W-1:0] granted_index_o,
  input logic [bfla_pkg::CNT_W-1:0] free_count_o,
  input logic                       pool_full_o
);

  // A stalled result word holds its payload.
  `ASSERT_DEF(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_o) && $stable(granted_index_o) && $stable(free_count_o))

  // A result without a grant carries a zero index.
  `ASSERT_DEF(a_no_grant_idx, out_valid_o && !granted_o |-> granted_index_o == '0)

  // The full flag agrees with the reported free count.
  `ASSERT_DEF(a_full_count, out_valid_o |-> pool_full_o == (free_count_o == '0))

  // A taken request keeps the input side busy for the following cycle.
  `ASSERT_DEF(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

endmodule

bind block_free_list_allocator_unit bfla_checker u_bfla_checker (.*);

// File: sim/block_free_list_allocator_unit_tb.sv
// Self-checking testbench for the block free list allocator top level.
// Depends on bfla_pkg and block_free_list_allocator_unit; drives random
// alloc/free traffic with pool-size changes and checks every result word.
`timescale 1ns / 1ps

module block_free_list_allocator_unit_tb;

  // Field widths of the interface.
  localparam int IDX_W = bfla_pkg::IDX_W;
  localparam int CNT_W = bfla_pkg::CNT_W;

  // Pool size that a register write can reach with the default parameter.
  localparam int POOL_CAP = (bfla_pkg::MAX_BLOCKS_DEF < bfla_pkg::INDEX_SPAN) ?
                            bfla_pkg::MAX_BLOCKS_DEF : bfla_pkg::INDEX_SPAN;
  localparam int RANDOM_WORDS = 800;

  // One request word as the sender presents it.
  typedef struct {
    logic             op;
    logic [IDX_W-1:0] index;
    bit               hold_for_drain;
  } request_t;

  // One result word as the allocator reports it.
  typedef struct {
    logic             granted;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } grant_t;

  // Receiver stall behaviors, one picked at random by the receiver.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             op_i = bfla_pkg::OP_ALLOC;
  logic [IDX_W-1:0] freed_index_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             granted_o;
  logic [IDX_W-1:0] granted_index_o;
  logic [CNT_W-1:0] free_count_o;
  logic             pool_empty_o;
  logic             pool_full_o;
  logic             cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  // Shadow of the allocator state.
  logic [CNT_W-1:0] pool_size;
  logic [CNT_W-1:0] next_fresh;
  logic [CNT_W-1:0] free_total;
  logic [IDX_W-1:0] head_idx;
  logic             list_live;
  logic [IDX_W-1:0] next_link [0:bfla_pkg::INDEX_SPAN-1];

  request_t    request_q[$];
  grant_t      pending_grants[$];
  int          error_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int unsigned stall_tick = 0;
  stall_mode_e stall_mode = STALL_NONE;

  block_free_list_allocator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .freed_index_i  (freed_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .granted_index_o(granted_index_o),
    .free_count_o   (free_count_o),
    .pool_empty_o   (pool_empty_o),
    .pool_full_o    (pool_full_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // A pool-size write empties the free list and restarts the bump pointer.
  function automatic void pool_reinit(logic [CNT_W-1:0] size);
    pool_size  = size;
    next_fresh = '0;
    free_total = size;
    head_idx   = '0;
    list_live  = 1'b0;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_size(logic [CNT_W-1:0] value);
    return (value > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : value;
  endfunction

  // Apply one request to the shadow state and queue the word it must produce.
  function automatic void predict_grant(logic op, logic [IDX_W-1:0] index);
    grant_t word;
    word = '{granted: 1'b0, index: '0, count: '0, empty: 1'b0, full: 1'b0};
    if (op == bfla_pkg::OP_ALLOC) begin
      if (next_fresh < pool_size) begin
        word.granted = 1'b1;
        word.index   = next_fresh[IDX_W-1:0];
        next_fresh   = next_fresh + 1'b1;
        if (free_total != 0) free_total = free_total - 1'b1;
      end else if (list_live && free_total != 0) begin
        word.granted = 1'b1;
        word.index   = head_idx;
        head_idx     = next_link[head_idx];
        free_total   = free_total - 1'b1;
        list_live    = (free_total != 0);
      end
    end else if ({1'b0, index} < pool_size && free_total < pool_size) begin
      next_link[index] = head_idx;
      head_idx         = index;
      list_live        = 1'b1;
      free_total       = free_total + 1'b1;
    end
    word.count = free_total;
    word.empty = (free_total == pool_size);
    word.full  = (free_total == 0);
    pending_grants.push_back(word);
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Sender: presents queued words in bursts separated by random gaps.
  always @(posedge clk_i) begin
    bit       taken;
    request_t word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) predict_grant(op_i, freed_index_i);
      if (in_valid_i && !taken) begin
        // Hold the stalled word unchanged.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0 &&
                   (!request_q[0].hold_for_drain || pending_grants.size() == 0)) begin
        word = request_q.pop_front();
        in_valid_i    <= 1'b1;
        op_i          <= word.op;
        freed_index_i <= word.index;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each taken result word and stalls on its own pattern.
  always @(posedge clk_i) begin
    grant_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: result word with none expected, actual count %0d",
                   $time, free_count_o);
          error_count++;
        end else begin
          want = pending_grants.pop_front();
          compare_field("granted", want.granted, granted_o);
          compare_field("granted_index", want.index, granted_index_o);
          compare_field("free_count", want.count, free_count_o);
          compare_field("pool_empty", want.empty, pool_empty_o);
          compare_field("pool_full", want.full, pool_full_o);
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE: begin
          out_stall_i <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall_i <= (stall_tick % 8 < 3);
        end
      endcase
    end
  end

  task automatic push_word(logic op, logic [IDX_W-1:0] index, bit hold = 1'b0);
    request_q.push_back('{op: op, index: index, hold_for_drain: hold});
  endtask

  // Wait until the sender is drained and every result word has arrived.
  task automatic settle();
    while (request_q.size() != 0 || in_valid_i || pending_grants.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_size(logic [CNT_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_reinit(clamp_size(value));
  endtask

  // Alternating runs of allocations and frees, mostly of in-range blocks.
  task automatic random_phase(int words, logic [CNT_W-1:0] size);
    int run_len;
    int run_cap;
    bit freeing;
    freeing = 1'b0;
    run_cap = (int'(size) + 2 > 40) ? 40 : int'(size) + 2;
    while (words > 0) begin
      run_len = $urandom_range(1, run_cap);
      for (int i = 0; i < run_len && words > 0; i++) begin
        if (!freeing) begin
          push_word(bfla_pkg::OP_ALLOC, IDX_W'($urandom), $urandom_range(0, 99) == 0);
        end else if (size != 0 && $urandom_range(0, 9) < 8) begin
          push_word(bfla_pkg::OP_FREE, IDX_W'($urandom_range(0, int'(size) - 1)),
                    $urandom_range(0, 99) == 0);
        end else begin
          push_word(bfla_pkg::OP_FREE, IDX_W'($urandom), 1'b0);
        end
        words--;
      end
      freeing = !freeing;
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int               left;
    int               words;
    int               pick;
    logic [CNT_W-1:0] value;
    pool_reinit(CNT_W'(POOL_CAP));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full pool after reset: bump allocations, frees at both index ends.
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'hFFF);
    push_word(bfla_pkg::OP_FREE, 12'hFFF);
    push_word(bfla_pkg::OP_ALLOC, 12'h555);
    push_word(bfla_pkg::OP_FREE, 12'h000, 1'b1);

    // One-block pool: exhaustion, out-of-range free, free when all free, pop.
    write_pool_size(13'd1);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_FREE, 12'h001);
    push_word(bfla_pkg::OP_FREE, 12'h000);
    push_word(bfla_pkg::OP_FREE, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'hAAA);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);

    // Empty pool: nothing ever granted, both flags set.
    write_pool_size(13'd0);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_FREE, 12'h000);

    // Oversized write is held at the pool capacity.
    write_pool_size(13'h1FFF);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_FREE, 12'hFFF);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);

    // Two blocks: drain the bump pointer, refill the list, pop it back out.
    write_pool_size(13'd2);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_FREE, 12'h001);
    push_word(bfla_pkg::OP_FREE, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);
    push_word(bfla_pkg::OP_ALLOC, 12'h000);

    // Random phases, each after a fresh pool-size write.
    left = RANDOM_WORDS;
    pick = 0;
    while (left > 0) begin
      if (pick == 0) begin
        value = 13'd4096;
      end else if (pick == 1) begin
        value = 13'd4095;
      end else begin
        case ($urandom_range(0, 19)) inside
          0:       value = 13'd0;
          1:       value = 13'd4096;
          2:       value = CNT_W'($urandom_range(4097, 8191));
          3:       value = 13'd4095;
          [4:5]:   value = CNT_W'($urandom_range(33, 600));
          default: value = CNT_W'($urandom_range(1, 32));
        endcase
      end
      pick++;
      write_pool_size(value);
      words = $urandom_range(20, 80);
      if (words > left) words = left;
      random_phase(words, clamp_size(value));
      left -= words;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
